// ===== sv/met_pkg.sv =====
`default_nettype none
package met_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_X_LEFT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOWER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITERS = 3'd4;

	localparam logic signed [31:0] X_LEFT_RST  = 32'shE000_0000;
	localparam logic signed [31:0] Y_LOWER_RST = 32'shE000_0000;
	localparam logic signed [31:0] STEP_RST    = 32'sh0010_0000;
	localparam logic [15:0]        ITERS_RST   = 16'd1000;

	typedef struct packed {
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
	} point_t;

endpackage
`default_nettype wire

// ===== sv/mandelbrot_escape_time_unit.sv =====
`default_nettype none
// Mandelbrot escape-time unit: each item (col, row) forms c = (x_left + col*x_step,
// y_lower + row*y_step) in Q4.28 and iterates z = z^2 + c in saturating Q8.28
// until |z|^2 >= 4 or the count reaches max_iters, returning the count. A two-stage
// front forms c at one item per cycle, unless stalled by a full queue, into a two-entry
// queue; the back engine runs one pixel at a time on a single shared 32x32 multiplier
// used three times per pass. The result sits in an output register, so the engine
// starts the next queued pixel while a result waits. The user must see that registers
// are written only while the unit is idle; the unit itself does not enforce this.
module mandelbrot_escape_time_unit #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int ITER_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [met_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [11:0]                       col,
	input  wire logic [11:0]                       row,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [15:0]                            iter_count
);
	import met_pkg::*;

	logic signed [31:0] x_left_q;
	logic signed [31:0] y_lower_q;
	logic signed [31:0] x_step_q;
	logic signed [31:0] y_step_q;
	logic [15:0]        max_iters_q;

	logic   pt_valid;
	logic   pt_stall;
	point_t pt_data;
	logic   q_valid;
	logic   q_take;
	point_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_left_q    <= X_LEFT_RST;
			y_lower_q   <= Y_LOWER_RST;
			x_step_q    <= STEP_RST;
			y_step_q    <= STEP_RST;
			max_iters_q <= ITERS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_LEFT:    x_left_q    <= $signed(cfg_data);
				REG_Y_LOWER:   y_lower_q   <= $signed(cfg_data);
				REG_X_STEP:    x_step_q    <= $signed(cfg_data);
				REG_Y_STEP:    y_step_q    <= $signed(cfg_data);
				REG_MAX_ITERS: max_iters_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	met_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.col     (col),
		.row     (row),
		.x_left  (x_left_q),
		.y_lower (y_lower_q),
		.x_step  (x_step_q),
		.y_step  (y_step_q),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt_data (pt_data)
	);

	met_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(pt_valid),
		.push_stall(pt_stall),
		.push_data (pt_data),
		.pop_valid (q_valid),
		.pop_take  (q_take),
		.pop_data  (q_data)
	);

	met_back #(
		.ITER_BITS(ITER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_data    (q_data),
		.max_iters (max_iters_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.iter_count(iter_count)
	);

endmodule
`default_nettype wire

// ===== sv/met_front.sv =====
`default_nettype none
module met_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [11:0]           col,
	input  wire logic [11:0]           row,
	input  wire logic signed [31:0]    x_left,
	input  wire logic signed [31:0]    y_lower,
	input  wire logic signed [31:0]    x_step,
	input  wire logic signed [31:0]    y_step,
	output logic                       pt_valid,
	input  wire logic                  pt_stall,
	output met_pkg::point_t            pt_data
);
	import met_pkg::*;

	localparam logic signed [45:0] Q32_MAX = 46'sd2147483647;
	localparam logic signed [45:0] Q32_MIN = -46'sd2147483648;

	logic [11:0]        col_eff;
	logic [11:0]        row_eff;
	logic signed [44:0] prod_re;
	logic signed [44:0] prod_im;
	logic signed [44:0] prod_re_s1;
	logic signed [44:0] prod_im_s1;
	logic               v_s1;
	logic signed [45:0] sum_re;
	logic signed [45:0] sum_im;
	point_t             pt_s2;
	logic               v_s2;
	logic               adv1;
	logic               adv2;

	function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
		if (v > Q32_MAX)
			return 32'sh7FFF_FFFF;
		else if (v < Q32_MIN)
			return 32'sh8000_0000;
		else
			return $signed(v[31:0]);
	endfunction

	always_comb begin
		col_eff = col;
		row_eff = row;
		if (32'(col) >= MAX_WIDTH)
			col_eff = 12'(MAX_WIDTH - 1);
		if (32'(row) >= MAX_HEIGHT)
			row_eff = 12'(MAX_HEIGHT - 1);
		prod_re = 45'($signed({1'b0, col_eff})) * 45'(x_step);
		prod_im = 45'($signed({1'b0, row_eff})) * 45'(y_step);
		sum_re = 46'(prod_re_s1) + 46'(x_left);
		sum_im = 46'(prod_im_s1) + 46'(y_lower);
	end

	assign adv2     = !v_s2 || !pt_stall;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;
	assign pt_valid = v_s2;
	assign pt_data  = pt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			prod_re_s1 <= prod_re;
			prod_im_s1 <= prod_im;
		end
		if (adv2 && v_s1) begin
			pt_s2.c_re <= sat32(sum_re);
			pt_s2.c_im <= sat32(sum_im);
		end
	end

endmodule
`default_nettype wire

// ===== sv/met_queue.sv =====
`default_nettype none
module met_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_stall,
	input  wire met_pkg::point_t  push_data,
	output logic                  pop_valid,
	input  wire logic             pop_take,
	output met_pkg::point_t       pop_data
);
	import met_pkg::*;

	point_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign push_stall = fill_q == 2'd2;
	assign pop_valid  = fill_q != 2'd0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_take && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== sv/met_back.sv =====
`default_nettype none
module met_back #(
	parameter int ITER_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	output logic                  q_take,
	input  wire met_pkg::point_t  q_data,
	input  wire logic [15:0]      max_iters,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [15:0]           iter_count
);
	import met_pkg::*;

	localparam int CNT_W = ITER_BITS < 16 ? ITER_BITS : 16;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_P0   = 3'd1;
	localparam logic [2:0] ST_P1   = 3'd2;
	localparam logic [2:0] ST_P2   = 3'd3;
	localparam logic [2:0] ST_P3   = 3'd4;

	localparam logic signed [37:0] Q36_MAX_W = 38'sd34359738367;
	localparam logic signed [37:0] Q36_MIN_W = -38'sd34359738368;
	localparam logic signed [35:0] Q36_MAX   = 36'sh7_FFFF_FFFF;
	localparam logic signed [35:0] Q36_MIN   = 36'sh8_0000_0000;
	localparam logic signed [36:0] ESC_LIMIT = 37'sd1073741824;

	typedef struct packed {
		logic [63:0] prod;
		logic        zero;
		logic        big;
		logic        neg;
	} mul_t;

	function automatic logic [35:0] mag36(input logic signed [35:0] v);
		return v[35] ? 36'(-v) : 36'(v);
	endfunction

	function automatic logic signed [35:0] sat36(input logic signed [37:0] v);
		if (v > Q36_MAX_W)
			return Q36_MAX;
		else if (v < Q36_MIN_W)
			return Q36_MIN;
		else
			return $signed(v[35:0]);
	endfunction

	function automatic logic signed [35:0] mul_finish(input mul_t m, input logic half);
		logic [36:0] s;
		logic [36:0] ns;
		s  = half ? m.prod[63:27] : {1'b0, m.prod[63:28]};
		ns = 37'd0 - s;
		if (m.zero)
			return '0;
		else if (m.big)
			return m.neg ? Q36_MIN : Q36_MAX;
		else if (m.neg)
			return (s > 37'h8_0000_0000) ? Q36_MIN : $signed(ns[35:0]);
		else
			return (s > 37'h7_FFFF_FFFF) ? Q36_MAX : $signed(s[35:0]);
	endfunction

	logic [2:0]         state_q;
	logic signed [31:0] c_re_q;
	logic signed [31:0] c_im_q;
	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic signed [35:0] xx_q;
	logic signed [35:0] yy_q;
	mul_t               mul_q;
	logic [CNT_W-1:0]   count_q;
	logic [15:0]        res_q;
	logic               res_v_q;

	logic signed [35:0] op_a;
	logic signed [35:0] op_b;
	logic [35:0]        mag_a;
	logic [35:0]        mag_b;
	mul_t               mul_d;
	logic [CNT_W-1:0]   limit;
	logic signed [36:0] esc_sum;
	logic signed [37:0] nx_sum;
	logic signed [37:0] ny_sum;
	logic               done;
	logic               res_load;

	always_comb begin
		case (state_q)
			ST_P1: begin
				op_a = x_q;
				op_b = x_q;
			end
			ST_P2: begin
				op_a = y_q;
				op_b = y_q;
			end
			default: begin
				op_a = x_q;
				op_b = y_q;
			end
		endcase
		mag_a      = mag36(op_a);
		mag_b      = mag36(op_b);
		mul_d.prod = 64'(mag_a[31:0]) * 64'(mag_b[31:0]);
		mul_d.zero = (mag_a == 36'd0) || (mag_b == 36'd0);
		mul_d.big  = (|mag_a[35:32]) || (|mag_b[35:32]);
		mul_d.neg  = op_a[35] ^ op_b[35];
	end

	assign limit    = max_iters[CNT_W-1:0];
	assign esc_sum  = 37'(xx_q) + 37'(yy_q);
	assign nx_sum   = 38'(xx_q) - 38'(yy_q) + 38'(c_re_q);
	assign ny_sum   = 38'(mul_finish(mul_q, 1'b1)) + 38'(c_im_q);
	assign done     = (count_q != '0) && ((esc_sum >= ESC_LIMIT) || (count_q >= limit));
	assign res_load = (state_q == ST_P0) && done && (!res_v_q || !out_stall);
	assign q_take   = (state_q == ST_IDLE) && q_valid;

	assign out_valid  = res_v_q;
	assign iter_count = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_v_q <= 1'b0;
		end else begin
			if (res_load)
				res_v_q <= 1'b1;
			else if (!out_stall)
				res_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid)
						state_q <= ST_P0;
				end
				ST_P0: begin
					if (!done)
						state_q <= ST_P1;
					else if (res_load)
						state_q <= ST_IDLE;
				end
				ST_P1: state_q <= ST_P2;
				ST_P2: state_q <= ST_P3;
				ST_P3: state_q <= ST_P0;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= 16'(count_q);
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					c_re_q  <= q_data.c_re;
					c_im_q  <= q_data.c_im;
					x_q     <= '0;
					y_q     <= '0;
					xx_q    <= '0;
					yy_q    <= '0;
					count_q <= '0;
				end
			end
			ST_P0: begin
				if (!done) begin
					mul_q <= mul_d;
					x_q   <= sat36(nx_sum);
				end
			end
			ST_P1: begin
				y_q   <= sat36(ny_sum);
				mul_q <= mul_d;
			end
			ST_P2: begin
				xx_q  <= mul_finish(mul_q, 1'b0);
				mul_q <= mul_d;
			end
			ST_P3: begin
				yy_q    <= mul_finish(mul_q, 1'b0);
				count_q <= count_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (count_q <= limit || count_q == CNT_W'(1)))
		else $error("iteration count ran past the limit");

	a_squares_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (!xx_q[35] && !yy_q[35]))
		else $error("squared term went negative");

	a_result_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> ($past(state_q) == ST_P0))
		else $error("result loaded outside the check step");

	a_result_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q |-> (iter_count != 16'd0))
		else $error("result count is zero");
`endif

endmodule
`default_nettype wire
